@@ src/assert_macros.svh @@
// Assertion helpers for the RTL files.
// ASSERT_CLK checks on every clock edge outside reset.
// ASSERT_ALWAYS checks on every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ src/rcsv_pkg.sv @@
package rcsv_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_Q_BITS     = SINE_TABLE_BITS - 2;
    localparam int SINE_Q          = 1 << SINE_Q_BITS;

    localparam logic [15:0] LEVEL_ONE = 16'd32768;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TIMEOUT   = 3'd0;
    localparam logic [2:0] CFG_ATTACK    = 3'd1;
    localparam logic [2:0] CFG_DECAY     = 3'd2;
    localparam logic [2:0] CFG_ACTIVE    = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_BASE_INC  = 3'd5;
    localparam logic [2:0] CFG_INC_ROT   = 3'd6;

    localparam logic [23:0] RST_TIMEOUT   = 24'd4800;
    localparam logic [15:0] RST_ATTACK    = 16'd33;
    localparam logic [15:0] RST_DECAY     = 16'd2;
    localparam logic [15:0] RST_ACTIVE    = 16'd16384;
    localparam logic [22:0] RST_THRESHOLD = 23'd66;
    localparam logic [31:0] RST_BASE_INC  = 32'd17895697;
    localparam logic [31:0] RST_INC_ROT   = 32'd13421773;

    localparam longint Q30  = 64'sd1073741824;
    localparam longint SC1  = 64'sd1686629713;
    localparam longint SC3  = -64'sd693598668;
    localparam longint SC5  = 64'sd85569306;
    localparam longint SC7  = -64'sd5026995;
    localparam longint SC9  = 64'sd172272;

    // Quarter-wave magnitudes for k = 1 .. SINE_Q; k = 0 is zero and not stored.
    typedef logic [14:0] t_sine_rom [SINE_Q];

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    u;
        longint    u2;
        longint    acc;
        longint    m;
        for (int k = 1; k <= SINE_Q; k++) begin
            u   = longint'(k) <<< (30 - SINE_Q_BITS);
            u2  = (u * u) >>> 30;
            acc = SC9;
            acc = SC7 + (acc * u2) / Q30;
            acc = SC5 + (acc * u2) / Q30;
            acc = SC3 + (acc * u2) / Q30;
            acc = SC1 + (acc * u2) / Q30;
            acc = (acc * u) / Q30;
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > Q30) begin
                acc = Q30;
            end
            m = (acc * 32767 + (Q30 >>> 1)) >>> 30;
            rom[k - 1] = m[14:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

@@ src/rotation_controlled_sine_voice.sv @@
// Sine voice with a linear envelope, steered by rotation messages. Each
// transaction on the input stream is a sample tick or a rotation message
// (tuser). A message whose rotation moved by more than the threshold
// retunes the oscillator and sets the target level to the active level;
// any other message sets the target to zero. Each tick ramps the level,
// emits one sample with the new level and advances the phase. The block
// takes one transaction per clock: the whole state update of an item
// closes between the input register and the state and result registers,
// and a tick waits only while the result register is full and not taken.
// A tick goes from the input register to the result register. The sine
// magnitude for the next phase is looked up when the phase advances, so
// the sample path holds only the level ramp and one multiplier.
`include "assert_macros.svh"

module rotation_controlled_sine_voice
    import rcsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] rotation
    input  logic        s_axis_tuser,   // [0] req_type

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] audio_sample, [31:16] envelope_level
);

    logic [23:0] r_timeout;
    logic [15:0] r_attack;
    logic [15:0] r_decay;
    logic [15:0] r_active;
    logic [22:0] r_threshold;
    logic [31:0] r_base_inc;
    logic [31:0] r_inc_rot;

    logic               r_in_valid;
    logic               r_in_req;
    logic signed [23:0] r_in_rot;

    logic [31:0]        r_phase;
    logic [31:0]        r_phase_inc;
    logic [15:0]        r_level;
    logic [15:0]        r_target;
    logic signed [23:0] r_last_rot;
    logic [23:0]        r_silence;
    logic [14:0]        r_sine_mag;
    logic               r_sine_neg;

    logic        r_out_valid;
    logic [15:0] r_out_sample;
    logic [15:0] r_out_level;

    logic w_out_free;
    logic w_adv;
    logic w_tick;
    logic w_msg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= RST_TIMEOUT;
            r_attack    <= RST_ATTACK;
            r_decay     <= RST_DECAY;
            r_active    <= RST_ACTIVE;
            r_threshold <= RST_THRESHOLD;
            r_base_inc  <= RST_BASE_INC;
            r_inc_rot   <= RST_INC_ROT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[23:0];
                CFG_ATTACK:    r_attack    <= i_cfg_data[15:0];
                CFG_DECAY:     r_decay     <= i_cfg_data[15:0];
                CFG_ACTIVE:    r_active    <= i_cfg_data[15:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[22:0];
                CFG_BASE_INC:  r_base_inc  <= i_cfg_data;
                CFG_INC_ROT:   r_inc_rot   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A message never needs the result register, so it always moves on.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && (r_in_req || w_out_free);
    assign w_tick        = w_adv && !r_in_req;
    assign w_msg         = w_adv && r_in_req;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req <= s_axis_tuser;
            r_in_rot <= s_axis_tdata;
        end
    end

    // Message path: movement test and retuning.
    logic signed [24:0] w_diff;
    logic        [24:0] w_abs_diff;
    logic               w_moved;
    logic signed [56:0] w_rot_prod;
    logic signed [57:0] w_inc_sum;
    logic        [41:0] w_inc_shift;
    logic        [31:0] w_new_inc;

    assign w_diff     = {r_in_rot[23], r_in_rot} - {r_last_rot[23], r_last_rot};
    assign w_abs_diff = w_diff[24] ? 25'(-w_diff) : 25'(w_diff);
    assign w_moved    = w_abs_diff > {2'b00, r_threshold};

    assign w_rot_prod  = $signed({{33{r_in_rot[23]}}, r_in_rot})
                       * $signed({25'd0, r_inc_rot});
    assign w_inc_sum   = $signed({10'd0, r_base_inc, 16'd0})
                       + $signed({w_rot_prod[56], w_rot_prod});
    assign w_inc_shift = w_inc_sum[57:16];

    always_comb begin
        if (w_inc_sum[57]) begin
            w_new_inc = 32'd0;
        end else if (|w_inc_shift[41:32]) begin
            w_new_inc = 32'hFFFFFFFF;
        end else begin
            w_new_inc = w_inc_shift[31:0];
        end
    end

    // Tick path: silence count, envelope ramp, sample.
    logic [23:0] n_silence;
    logic [15:0] w_target_eff;
    logic [16:0] w_level_up;
    logic [15:0] n_level;

    assign n_silence    = (r_silence == COUNT_MAX) ? r_silence : r_silence + 24'd1;
    assign w_target_eff = (n_silence > r_timeout) ? 16'd0 : r_target;
    assign w_level_up   = {1'b0, r_level} + {1'b0, r_attack};

    always_comb begin
        if (r_level < w_target_eff) begin
            n_level = (w_level_up > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : w_level_up[15:0];
        end else if (r_level > w_target_eff) begin
            n_level = (r_level > r_decay) ? r_level - r_decay : 16'd0;
        end else begin
            n_level = r_level;
        end
    end

    logic [31:0] w_mix;
    logic [15:0] w_mag;
    logic [15:0] w_sample;

    assign w_mix    = {17'd0, r_sine_mag} * {16'd0, n_level} + 32'd16384;
    assign w_mag    = w_mix[30:15];
    assign w_sample = r_sine_neg ? 16'(16'd0 - w_mag) : w_mag;

    // Quarter-wave lookup for the phase that the next tick will use.
    logic [31:0]                n_phase;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [SINE_Q_BITS-1:0]     w_rem;
    logic [SINE_Q_BITS:0]       w_k;
    logic [SINE_Q_BITS:0]       w_k_m1;
    logic [14:0]                n_sine_mag;

    localparam logic [SINE_Q_BITS:0] SINE_Q_K = (SINE_Q_BITS + 1)'(SINE_Q);

    assign n_phase = r_phase + r_phase_inc;
    assign w_idx   = n_phase[31 -: SINE_TABLE_BITS];
    assign w_rem   = w_idx[SINE_Q_BITS-1:0];
    assign w_k     = w_idx[SINE_Q_BITS] ? SINE_Q_K - {1'b0, w_rem} : {1'b0, w_rem};
    assign w_k_m1  = w_k - 1'b1;

    always_comb begin
        if (w_k == '0) begin
            n_sine_mag = 15'd0;
        end else begin
            n_sine_mag = SINE_ROM[w_k_m1[SINE_Q_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 32'd0;
            r_phase_inc <= RST_BASE_INC;
            r_level     <= 16'd0;
            r_target    <= 16'd0;
            r_last_rot  <= 24'sd0;
            r_silence   <= 24'd0;
            r_sine_mag  <= 15'd0;
            r_sine_neg  <= 1'b0;
        end else if (w_msg) begin
            if (w_moved) begin
                r_phase_inc <= w_new_inc;
                r_target    <= r_active;
            end else begin
                r_target    <= 16'd0;
            end
            r_last_rot <= r_in_rot;
            r_silence  <= 24'd0;
        end else if (w_tick) begin
            r_silence  <= n_silence;
            r_target   <= w_target_eff;
            r_level    <= n_level;
            r_phase    <= n_phase;
            r_sine_mag <= n_sine_mag;
            r_sine_neg <= n_phase[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out_sample <= w_sample;
            r_out_level  <= n_level;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_level, r_out_sample};

    `ASSERT_CLK(a_level_bounded, i_clk, i_rst_n, r_level <= LEVEL_ONE)
    `ASSERT_CLK(a_tick_gives_result, i_clk, i_rst_n, w_tick |=> r_out_valid)
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n,
        !s_axis_tready |-> (r_in_valid && !r_in_req && r_out_valid && !m_axis_tready))
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid))

endmodule

@@ verif/sine_voice_tb_pkg.sv @@
package sine_voice_tb_pkg;

    // Kind of an input transaction, carried on tuser.
    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_ROTATION = 1'b1;

endpackage

@@ verif/sine_voice_checker.sv @@
module sine_voice_checker
    import rcsv_pkg::*;
    import sine_voice_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_rotation,
    input  logic        i_in_kind,

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,

    output int          o_results_due,
    output int          o_mismatches
);

    localparam longint ONE_Q30 = longint'(1) << 30;
    localparam longint TAY_C1  = 1686629713;
    localparam longint TAY_C3  = -693598668;
    localparam longint TAY_C5  = 85569306;
    localparam longint TAY_C7  = -5026995;
    localparam longint TAY_C9  = 172272;

    // Packed to match the output bus: level in the upper half.
    typedef struct packed {
        logic [15:0] level;
        logic [15:0] sample;
    } t_voice_out;

    t_voice_out samples_due [$];

    logic [23:0] timeout_cfg;
    logic [15:0] attack_cfg;
    logic [15:0] decay_cfg;
    logic [15:0] active_cfg;
    logic [22:0] threshold_cfg;
    logic [31:0] base_inc_cfg;
    logic [31:0] inc_per_rot_cfg;

    logic [31:0]        phase_acc;
    logic [31:0]        phase_step;
    int unsigned        env_level;
    logic [15:0]        target_level;
    logic signed [23:0] last_rot;
    logic [23:0]        silence;

    int mismatch_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    task automatic report_mismatch(input string msg);
        $display("%0t sine_voice_checker: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Signed sine table entry for the top bits of the phase, built from a
    // quarter wave by folding on the quadrant.
    function automatic int sine_entry(input logic [31:0] ph);
        int     idx;
        int     quad;
        int     k;
        longint u;
        longint u2;
        longint acc;
        idx  = int'(ph >> (32 - SINE_TABLE_BITS));
        quad = idx >> SINE_Q_BITS;
        k    = idx % SINE_Q;
        if (quad % 2 == 1) begin
            k = SINE_Q - k;
        end
        u   = longint'(k) << (30 - SINE_Q_BITS);
        u2  = (u * u) >>> 30;
        acc = TAY_C9;
        acc = TAY_C7 + (acc * u2) / ONE_Q30;
        acc = TAY_C5 + (acc * u2) / ONE_Q30;
        acc = TAY_C3 + (acc * u2) / ONE_Q30;
        acc = TAY_C1 + (acc * u2) / ONE_Q30;
        acc = (acc * u) / ONE_Q30;
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > ONE_Q30) begin
            acc = ONE_Q30;
        end
        k = int'((acc * 32767 + ONE_Q30 / 2) >>> 30);
        return (quad < 2) ? k : -k;
    endfunction

    task automatic step_voice(input logic kind, input logic [23:0] rotation);
        logic signed [23:0] rot;
        int                 diff;
        longint             lrot;
        longint             lbase;
        longint             linc;
        longint             sum;
        int                 ent;
        int unsigned        mag;
        t_voice_out         res;
        if (kind == REQ_ROTATION) begin
            rot  = rotation;
            diff = int'(rot) - int'(last_rot);
            if (diff < 0) begin
                diff = -diff;
            end
            if (diff > int'(threshold_cfg)) begin
                lrot  = rot;
                lbase = base_inc_cfg;
                linc  = inc_per_rot_cfg;
                sum   = lbase * 65536 + lrot * linc;
                if (sum < 0) begin
                    phase_step = '0;
                end else if ((sum >>> 16) > 64'hFFFF_FFFF) begin
                    phase_step = '1;
                end else begin
                    phase_step = 32'(sum >>> 16);
                end
                target_level = active_cfg;
            end else begin
                target_level = '0;
            end
            last_rot = rot;
            silence  = '0;
        end else begin
            if (silence != COUNT_MAX) begin
                silence++;
            end
            if (silence > timeout_cfg) begin
                target_level = '0;
            end
            if (env_level < target_level) begin
                env_level += attack_cfg;
                if (env_level > LEVEL_ONE) begin
                    env_level = LEVEL_ONE;
                end
            end else if (env_level > target_level) begin
                env_level = (env_level > decay_cfg) ? env_level - decay_cfg : 0;
            end
            ent        = sine_entry(phase_acc);
            mag        = (((ent < 0) ? -ent : ent) * env_level + 16384) >> 15;
            res.sample = 16'((ent < 0) ? -int'(mag) : int'(mag));
            res.level  = 16'(env_level);
            samples_due.push_back(res);
            phase_acc += phase_step;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_voice_out got;
        t_voice_out want;
        if (!i_rst_n) begin
            timeout_cfg     = RST_TIMEOUT;
            attack_cfg      = RST_ATTACK;
            decay_cfg       = RST_DECAY;
            active_cfg      = RST_ACTIVE;
            threshold_cfg   = RST_THRESHOLD;
            base_inc_cfg    = RST_BASE_INC;
            inc_per_rot_cfg = RST_INC_ROT;
            phase_acc       = '0;
            phase_step      = RST_BASE_INC;
            env_level       = 0;
            target_level    = '0;
            last_rot        = '0;
            silence         = '0;
            samples_due.delete();
            o_results_due  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIMEOUT:   timeout_cfg     = i_cfg_data[23:0];
                    CFG_ATTACK:    attack_cfg      = i_cfg_data[15:0];
                    CFG_DECAY:     decay_cfg       = i_cfg_data[15:0];
                    CFG_ACTIVE:    active_cfg      = i_cfg_data[15:0];
                    CFG_THRESHOLD: threshold_cfg   = i_cfg_data[22:0];
                    CFG_BASE_INC:  base_inc_cfg    = i_cfg_data;
                    CFG_INC_ROT:   inc_per_rot_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            // Compare before predicting so that a result never pairs with
            // a tick accepted on the same edge.
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (samples_due.size() == 0) begin
                    report_mismatch($sformatf("result %h with none outstanding", i_out_data));
                end else begin
                    want = samples_due.pop_front();
                    if (got.sample != want.sample) begin
                        report_mismatch($sformatf("audio_sample got %0d want %0d",
                            $signed(got.sample), $signed(want.sample)));
                    end
                    if (got.level != want.level) begin
                        report_mismatch($sformatf("envelope_level got %0d want %0d",
                            got.level, want.level));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_voice(i_in_kind, i_in_rotation);
            end
            o_results_due <= samples_due.size();
        end
    end

endmodule

@@ verif/tb_rotation_controlled_sine_voice.sv @@
module tb_rotation_controlled_sine_voice;
    import rcsv_pkg::*;
    import sine_voice_tb_pkg::*;

    localparam int         CYCLE_LIMIT     = 300000;
    localparam int         RANDOM_PHASES   = 9;
    localparam int         ITEMS_PER_PHASE = 45;
    localparam int         SETTLE_CYCLES   = 8;
    localparam logic [2:0] CFG_UNUSED      = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    int results_due;
    int mismatches;
    int cycle_count = 0;
    int sink_hold   = 0;
    logic sink_calm    = 1'b0;
    logic sender_burst = 1'b0;

    logic signed [23:0] last_rot      = '0;
    logic [22:0]        cur_threshold = RST_THRESHOLD;
    logic [31:0]        next_settings [CFG_TIMEOUT:CFG_INC_ROT];

    rotation_controlled_sine_voice uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sine_voice_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_rotation (s_axis_tdata),
        .i_in_kind     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_results_due (results_due),
        .o_mismatches  (mismatches)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_rotation_controlled_sine_voice: FAIL");
            $finish;
        end
    end

    // Result sink: stretches of steady acceptance alternate with choppy ones.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            sink_calm <= ~sink_calm;
        end
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
            sink_hold     <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        case (idx)
            CFG_TIMEOUT:                       return 32'h00FF_FFFF;
            CFG_ATTACK, CFG_DECAY, CFG_ACTIVE: return 32'h0000_FFFF;
            CFG_THRESHOLD:                     return 32'h007F_FFFF;
            default:                           return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_value(input logic [2:0] idx);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return reg_mask(idx);
            2: return $urandom & reg_mask(idx);
            default: begin
                case (idx)
                    CFG_TIMEOUT:           return $urandom_range(0, 60);
                    CFG_ATTACK, CFG_DECAY: return ($urandom_range(0, 3) == 0) ?
                                                  32'(LEVEL_ONE) : $urandom_range(1, 3000);
                    CFG_ACTIVE:            return $urandom_range(0, 32768);
                    CFG_THRESHOLD:         return $urandom_range(0, 400);
                    CFG_BASE_INC:          return $urandom;
                    default:               return $urandom_range(0, 32'h0400_0000);
                endcase
            end
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [23:0] rot);
        int gap;
        gap = 0;
        if (!sender_burst && $urandom_range(0, 99) < 30) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom);
            s_axis_tuser  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        // A tick ignores the rotation field, so it carries noise.
        s_axis_tdata  <= (kind == REQ_ROTATION) ? rot : 24'($urandom);
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == REQ_ROTATION) begin
            last_rot = rot;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
        // A trailing message has no result, so give it time to settle.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_THRESHOLD) begin
            cur_threshold = data[22:0];
        end
    endtask

    task automatic load_settings(input bit poke_unused);
        drain();
        // Bits above each register's width are filled with noise.
        for (int i = CFG_TIMEOUT; i <= CFG_INC_ROT; i++) begin
            write_reg(3'(i), next_settings[i] | ($urandom & ~reg_mask(3'(i))));
        end
        if (poke_unused) begin
            write_reg(CFG_UNUSED, $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned        pick;
        int                 delta;
        logic signed [23:0] rot;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            send_item(REQ_TICK, '0);
        end else begin
            if (pick < 86) begin
                // Steps right around the movement threshold.
                delta = int'(cur_threshold) + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1) begin
                    delta = -delta;
                end
                rot = last_rot + 24'(delta);
            end else if (pick < 92) begin
                rot = last_rot;
            end else begin
                rot = 24'($urandom);
            end
            send_item(REQ_ROTATION, rot);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: silence, no movement, a threshold step just over
        // and exactly at the limit, and both rotation extremes.
        send_item(REQ_TICK, '0);
        send_item(REQ_TICK, '0);
        send_item(REQ_ROTATION, 24'sd0);
        send_item(REQ_ROTATION, 24'sd67);
        repeat (4) send_item(REQ_TICK, '0);
        send_item(REQ_ROTATION, 24'sd133);
        repeat (2) send_item(REQ_TICK, '0);
        send_item(REQ_ROTATION, 24'h800000);
        repeat (2) send_item(REQ_TICK, '0);
        send_item(REQ_ROTATION, 24'h7FFFFF);
        repeat (2) send_item(REQ_TICK, '0);

        // Full-scale steps and increments: the level saturates at one even
        // with an active level above one, the increment clamps at both
        // ends, and a short timeout drops the voice.
        next_settings[CFG_TIMEOUT]   = 32'd3;
        next_settings[CFG_ATTACK]    = 32'hFFFF;
        next_settings[CFG_DECAY]     = 32'hFFFF;
        next_settings[CFG_ACTIVE]    = 32'hFFFF;
        next_settings[CFG_THRESHOLD] = 32'd0;
        next_settings[CFG_BASE_INC]  = 32'hFFFF_FFFF;
        next_settings[CFG_INC_ROT]   = 32'hFFFF_FFFF;
        load_settings(1'b1);
        send_item(REQ_ROTATION, 24'sd1);
        repeat (5) send_item(REQ_TICK, '0);
        send_item(REQ_ROTATION, 24'sd1);
        send_item(REQ_ROTATION, 24'h800000);
        send_item(REQ_TICK, '0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int i = CFG_TIMEOUT; i <= CFG_INC_ROT; i++) begin
                next_settings[i] = (ph == 0) ? '0 : pick_value(3'(i));
            end
            load_settings($urandom_range(0, 3) == 0);
            sender_burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_item();
                if ($urandom_range(0, 59) == 0) begin
                    drain();
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (int w = 0; w < 4000 && results_due != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && results_due == 0) begin
            $display("tb_rotation_controlled_sine_voice: PASS");
        end else begin
            $display("tb_rotation_controlled_sine_voice: FAIL");
        end
        $finish;
    end

endmodule
